### hw/rtl/binary_to_decimal_ascii_core_assert.svh
// Assertion macros for the binary to decimal ASCII core
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define B2DA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define B2DA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define B2DA_ASSERT(lbl, prop, msg)
`define B2DA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hw/rtl/b2da_pkg.sv
// Shared constants and helpers for the binary to decimal ASCII core
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;
    localparam int BITS_PER_STAGE      = 4;
    localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;   // '0'..'9' masked to 6 bits

    // decimal digits needed for the largest value of a given bit width
    function automatic int num_digits(input int width);
        return (width * 30103) / 100000 + 1;
    endfunction

    // shift-and-add-3 correction of one BCD digit
    function automatic logic [3:0] dabble_fix(input logic [3:0] nib);
        logic [3:0] res;
        res = (nib >= 4'd5) ? nib + 4'd3 : nib;
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/b2da_dabble_stage.sv
// One register stage of the pipelined binary to BCD converter
`timescale 1ns / 1ps
`default_nettype none

module b2da_dabble_stage
    import b2da_pkg::*;
#(
    parameter int PW = 32,
    parameter int BW = 40,
    parameter int K  = BITS_PER_STAGE
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output      logic          in_ready,
    input  wire logic [PW-1:0] in_bin,
    input  wire logic [BW-1:0] in_bcd,
    output      logic          out_valid,
    input  wire logic          out_ready,
    output      logic [PW-1:0] out_bin,
    output      logic [BW-1:0] out_bcd
);

    localparam int ND = BW / 4;

    logic          valid_reg;
    logic [PW-1:0] bin_reg;
    logic [BW-1:0] bcd_reg;
    logic [PW-1:0] bin_next;
    logic [BW-1:0] bcd_next;

    always_comb
    begin
        bin_next = in_bin;
        bcd_next = in_bcd;
        for (int k = 0; k < K; k++)
        begin
            for (int n = 0; n < ND; n++)
            begin
                bcd_next[n*4 +: 4] = dabble_fix(bcd_next[n*4 +: 4]);
            end
            bcd_next = {bcd_next[BW-2:0], bin_next[PW-1]};
            bin_next = {bin_next[PW-2:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_bcd   = bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/binary_to_decimal_ascii_core.sv
// Top level: pipelined binary to decimal ASCII converter with digit serializer
//
//  channel | signals                                  | direction
//  value   | value_valid, value_ready, value          | in
//  digit   | digit_valid, digit_ready, digit_char,    | out
//          | last_digit                               |
//
// An item passes ceil(VALUE_WIDTH/4) dabble stages (four bits each), one digit
// count stage and the serializer, each registered. The serializer sends one digit
// per cycle while digit_ready is high; an item has 1 to num_digits digits (10 at
// 32 bits), and the next item loads only as the last digit is taken.
// Reset clears only valid bits and the digit index; a stall at digit_ready
// backs up the pipeline stage by stage without loss.
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_core_assert.svh"

module binary_to_decimal_ascii_core
    import b2da_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   value_valid,
    output      logic                   value_ready,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output      logic                   digit_valid,
    input  wire logic                   digit_ready,
    output      logic [5:0]             digit_char,
    output      logic                   last_digit
);

    localparam int NDIG = num_digits(VALUE_WIDTH);
    localparam int NSTG = (VALUE_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int PW   = NSTG * BITS_PER_STAGE;
    localparam int BW   = NDIG * 4;
    localparam int IW   = $clog2(NDIG);

    logic          stg_valid [NSTG+1];
    logic          stg_ready [NSTG+1];
    logic [PW-1:0] stg_bin   [NSTG+1];
    logic [BW-1:0] stg_bcd   [NSTG+1];

    assign stg_valid[0] = value_valid;
    assign stg_bin[0]   = PW'(value);
    assign stg_bcd[0]   = '0;
    assign value_ready  = stg_ready[0];

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stage
        b2da_dabble_stage #(
            .PW (PW),
            .BW (BW),
            .K  (BITS_PER_STAGE)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[s]),
            .in_ready  (stg_ready[s]),
            .in_bin    (stg_bin[s]),
            .in_bcd    (stg_bcd[s]),
            .out_valid (stg_valid[s+1]),
            .out_ready (stg_ready[s+1]),
            .out_bin   (stg_bin[s+1]),
            .out_bcd   (stg_bcd[s+1])
        );
    end

    // digit count stage: find the most significant nonzero digit
    logic          cnt_valid_reg;
    logic [BW-1:0] cnt_bcd_reg;
    logic [IW-1:0] cnt_top_reg;
    logic [IW-1:0] cnt_top_next;
    logic          cnt_ready;

    always_comb
    begin
        cnt_top_next = '0;
        for (int n = 0; n < NDIG; n++)
        begin
            if (stg_bcd[NSTG][n*4 +: 4] != 4'd0)
            begin
                cnt_top_next = IW'(n);
            end
        end
    end

    // serializer
    logic          ser_valid_reg;
    logic [BW-1:0] ser_bcd_reg;
    logic [IW-1:0] ser_idx_reg;
    logic          ser_done;
    logic          ser_load;
    logic [3:0]    ser_nib;

    assign ser_done  = !ser_valid_reg || (digit_ready && ser_idx_reg == '0);
    assign ser_load  = cnt_valid_reg && ser_done;
    assign cnt_ready = !cnt_valid_reg || ser_done;
    assign stg_ready[NSTG] = cnt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
        end
        else if (cnt_ready)
        begin
            cnt_valid_reg <= stg_valid[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_ready && stg_valid[NSTG])
        begin
            cnt_bcd_reg <= stg_bcd[NSTG];
            cnt_top_reg <= cnt_top_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end
        else if (ser_done)
        begin
            ser_valid_reg <= cnt_valid_reg;
            if (cnt_valid_reg)
            begin
                ser_idx_reg <= cnt_top_reg;
            end
        end
        else if (digit_ready)
        begin
            // advance to the next lower digit
            ser_idx_reg <= ser_idx_reg - IW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load)
        begin
            ser_bcd_reg <= cnt_bcd_reg;
        end
    end

    assign ser_nib     = ser_bcd_reg[{ser_idx_reg, 2'b00} +: 4];
    assign digit_valid = ser_valid_reg;
    assign digit_char  = {ASCII_DIGIT_HI, ser_nib};
    assign last_digit  = (ser_idx_reg == '0);

    `B2DA_ASSERT(a_idx_range, (!ser_valid_reg || (int'(ser_idx_reg) < NDIG)),
                 "digit index out of range")
    `B2DA_ASSERT(a_top_nonzero,
                 (!cnt_valid_reg || cnt_top_reg == '0
                  || cnt_bcd_reg[{cnt_top_reg, 2'b00} +: 4] != 4'd0),
                 "leading zero digit")
    `B2DA_ASSERT(a_bcd_digit, (!ser_valid_reg || ser_nib <= 4'd9), "invalid BCD digit")
    `B2DA_ASSERT_NEXT(a_run_continues,
                      (ser_valid_reg && digit_ready && ser_idx_reg != '0),
                      ser_valid_reg, "digit run ended early")

endmodule

`default_nettype wire
